@@ rtl/tvu_pkg.sv @@
// Shared widths, constants and the divider pipeline beat type for the TSDF voxel update core.
package tvu_pkg;

  localparam int TsdfW   = 16;
  localparam int WeightW = 8;
  localparam int DistW   = 17;
  localparam int TruncW  = 13;
  localparam int DenW    = 22;
  localparam int RemW    = 38;
  localparam int QuoW    = 16;

  localparam logic [TruncW-1:0] TruncReset = 13'd246;
  localparam logic [QuoW-1:0]   QMax       = 16'd32767;

  typedef struct packed {
    logic                 valid;
    logic                 fuse;
    logic                 neg;
    logic [RemW-1:0]      rem;
    logic [DenW-1:0]      den;
    logic [QuoW-1:0]      quo;
    logic [TsdfW-1:0]     raw_tsdf;
    logic [WeightW-1:0]   raw_weight;
    logic [WeightW-1:0]   new_weight;
  } div_beat_t;

endpackage

@@ rtl/tvu_div_step.sv @@
// One registered restoring-division stage that resolves a single quotient bit.
module tvu_div_step #(
  parameter int BIT = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  tvu_pkg::div_beat_t  din,
  output tvu_pkg::div_beat_t  dout
);

  logic [tvu_pkg::RemW-1:0] dsh;
  logic                     fits;
  tvu_pkg::div_beat_t       dout_next;

  always_comb begin
    dsh       = tvu_pkg::RemW'(din.den) << BIT;
    fits      = din.rem >= dsh;
    dout_next = din;
    if (fits) begin
      dout_next.rem      = din.rem - dsh;
      dout_next.quo[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout <= dout_next;
    end
  end

endmodule

@@ rtl/tsdf_voxel_update_core.sv @@
// Top level of the pipelined TSDF voxel update core.
//
//   Channel   Direction  Contents
//   s_axis    in         tdata: previous_tsdf[15:0], previous_weight[23:16],
//                        measured_depth[40:24], voxel_distance[57:41]; tuser: in_view
//   m_axis    out        tdata: new_tsdf[15:0], new_weight[23:16]; tuser: updated
//   cfg_wr    in         truncation_distance, written when cfg_wr_en is high
//
// One beat is accepted every cycle while the output is not stalled. Each beat passes
// through stages 1 to 4, the 16-stage restoring divider, one quotient bit per stage,
// and the output register. Reset clears all valid bits and sets the truncation distance
// to 246. A stalled output freezes the whole pipeline, so no beat is lost or repeated.
module tsdf_voxel_update_core #(
  parameter int MAX_WEIGHT = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // previous_tsdf, previous_weight, measured_depth,
                                      // voxel_distance, zero fill
  input  logic        s_axis_tuser,   // in_view
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // new_tsdf, new_weight
  output logic        m_axis_tuser,   // updated
  input  logic        cfg_wr_en,
  input  logic [12:0] cfg_wr_data
);

  localparam logic [15:0] MaxWeight = 16'(MAX_WEIGHT);

  logic                                 en;
  logic [tvu_pkg::TruncW-1:0]           trunc;
  logic [tvu_pkg::TruncW-1:0]           t_eff;

  logic signed [tvu_pkg::TsdfW-1:0]     in_tsdf;
  logic [tvu_pkg::WeightW-1:0]          in_weight;
  logic [tvu_pkg::DistW-1:0]            in_depth;
  logic [tvu_pkg::DistW-1:0]            in_dist;
  logic signed [tvu_pkg::TsdfW-1:0]     p;
  logic signed [17:0]                   sdf;
  logic signed [17:0]                   t_s;
  logic                                 fuse_c;
  logic [8:0]                           wp1_c;
  logic [tvu_pkg::WeightW-1:0]          nw_c;

  logic                                 s1_valid;
  logic                                 s1_fuse;
  logic signed [24:0]                   s1_pw;
  logic signed [13:0]                   s1_scl;
  logic [tvu_pkg::TruncW-1:0]           s1_t;
  logic [8:0]                           s1_wp1;
  logic [tvu_pkg::TsdfW-1:0]            s1_raw_tsdf;
  logic [tvu_pkg::WeightW-1:0]          s1_raw_weight;
  logic [tvu_pkg::WeightW-1:0]          s1_new_weight;

  logic                                 s2_valid;
  logic                                 s2_fuse;
  logic signed [38:0]                   s2_pwt;
  logic signed [29:0]                   s2_m;
  logic [tvu_pkg::DenW-1:0]             s2_den;
  logic [tvu_pkg::TsdfW-1:0]            s2_raw_tsdf;
  logic [tvu_pkg::WeightW-1:0]          s2_raw_weight;
  logic [tvu_pkg::WeightW-1:0]          s2_new_weight;

  logic                                 s3_valid;
  logic                                 s3_fuse;
  logic signed [38:0]                   s3_num;
  logic [tvu_pkg::DenW-1:0]             s3_den;
  logic [tvu_pkg::TsdfW-1:0]            s3_raw_tsdf;
  logic [tvu_pkg::WeightW-1:0]          s3_raw_weight;
  logic [tvu_pkg::WeightW-1:0]          s3_new_weight;

  logic signed [38:0]                   num_abs;
  tvu_pkg::div_beat_t                   div_in;
  tvu_pkg::div_beat_t                   div_pipe [0:tvu_pkg::QuoW];
  tvu_pkg::div_beat_t                   div_last;
  logic [tvu_pkg::QuoW-1:0]             q_clamped;
  logic [tvu_pkg::QuoW-1:0]             q_signed;

  assign en            = ~m_axis_tvalid | m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      trunc <= tvu_pkg::TruncReset;
    end else if (cfg_wr_en) begin
      trunc <= cfg_wr_data;
    end
  end

  assign t_eff = (trunc == '0) ? tvu_pkg::TruncW'(1) : trunc;

  // Stage 1: signed distance, fuse decision, stored value times weight, clamped distance and new weight.
  always_comb begin
    in_tsdf   = s_axis_tdata[15:0];
    in_weight = s_axis_tdata[23:16];
    in_depth  = s_axis_tdata[40:24];
    in_dist   = s_axis_tdata[57:41];
    p         = (in_tsdf[15] && in_tsdf[0]) ? in_tsdf + 16'sd1 : (in_tsdf & ~16'sd1);
    sdf       = $signed({1'b0, in_depth}) - $signed({1'b0, in_dist});
    t_s       = $signed({5'b0, t_eff});
    fuse_c    = s_axis_tuser && (in_depth != '0) && (sdf >= -t_s);
    wp1_c     = {1'b0, in_weight} + 9'd1;
    nw_c      = ({7'b0, wp1_c} > MaxWeight) ? MaxWeight[7:0] : wp1_c[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= s_axis_tvalid;
    end
    if (en) begin
      s1_fuse       <= fuse_c;
      s1_pw         <= p * $signed({1'b0, in_weight});
      s1_scl        <= (sdf > t_s) ? $signed({1'b0, t_eff}) : sdf[13:0];
      s1_t          <= t_eff;
      s1_wp1        <= wp1_c;
      s1_raw_tsdf   <= in_tsdf;
      s1_raw_weight <= in_weight;
      s1_new_weight <= nw_c;
    end
  end

  // Stage 2: scale by the truncation band and form the divisor.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
    if (en) begin
      s2_fuse       <= s1_fuse;
      s2_pwt        <= s1_pw * $signed({1'b0, s1_t});
      s2_m          <= s1_scl * $signed(16'sd32767);
      s2_den        <= s1_wp1 * s1_t;
      s2_raw_tsdf   <= s1_raw_tsdf;
      s2_raw_weight <= s1_raw_weight;
      s2_new_weight <= s1_new_weight;
    end
  end

  // Stage 3: numerator.
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
    if (en) begin
      s3_fuse       <= s2_fuse;
      s3_num        <= s2_pwt + 39'(s2_m);
      s3_den        <= s2_den;
      s3_raw_tsdf   <= s2_raw_tsdf;
      s3_raw_weight <= s2_raw_weight;
      s3_new_weight <= s2_new_weight;
    end
  end

  // Stage 4: sign and magnitude of the numerator enter the divider.
  assign num_abs = s3_num[38] ? -s3_num : s3_num;

  always_ff @(posedge clk) begin
    if (rst) begin
      div_in.valid <= 1'b0;
    end else if (en) begin
      div_in.valid <= s3_valid;
    end
    if (en) begin
      div_in.fuse       <= s3_fuse;
      div_in.neg        <= s3_num[38];
      div_in.rem        <= num_abs[tvu_pkg::RemW-1:0];
      div_in.den        <= s3_den;
      div_in.quo        <= '0;
      div_in.raw_tsdf   <= s3_raw_tsdf;
      div_in.raw_weight <= s3_raw_weight;
      div_in.new_weight <= s3_new_weight;
    end
  end

  assign div_pipe[0] = div_in;

  for (genvar i = 0; i < tvu_pkg::QuoW; i++) begin : g_div
    tvu_div_step #(
      .BIT(tvu_pkg::QuoW - 1 - i)
    ) u_step (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .din  (div_pipe[i]),
      .dout (div_pipe[i+1])
    );
  end

  assign div_last  = div_pipe[tvu_pkg::QuoW];
  assign q_clamped = (div_last.quo > tvu_pkg::QMax) ? tvu_pkg::QMax : div_last.quo;
  assign q_signed  = div_last.neg ? -q_clamped : q_clamped;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= div_last.valid;
    end
    if (en) begin
      if (div_last.fuse) begin
        m_axis_tdata <= {div_last.new_weight, q_signed};
        m_axis_tuser <= 1'b1;
      end else begin
        m_axis_tdata <= {div_last.raw_weight, div_last.raw_tsdf};
        m_axis_tuser <= 1'b0;
      end
    end
  end

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while output is stalled");

  a_accept_enters_pipe: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> s1_valid)
    else $error("accepted beat did not enter the first stage");

  a_quotient_in_range: assert property (@(posedge clk) disable iff (rst)
    (div_last.valid && div_last.fuse) |-> !div_last.quo[tvu_pkg::QuoW-1])
    else $error("divider quotient out of range");

  a_fused_clamped: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[15:0] != 16'h8000))
    else $error("fused value not clamped");

endmodule
